[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define SID_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication, disabled during reset
`define SID_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define SID_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`define SID_ASSERT_NXT(lbl, clk, rst_n, a, b, msg)
`endif

`endif

[rtl/sid_pkg.sv]
// ----------------------------------------------------------------------------
// sid_pkg
// Command and status types shared by the divider controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // take operands, magnitudes and special-case flags
        logic step;     // settle one quotient bit
        logic capture;  // write the output register
    } sid_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic special;  // zero divisor or most-negative over minus one
    } sid_status_t;

endpackage

`default_nettype wire

[rtl/sid_ctrl.sv]
// ----------------------------------------------------------------------------
// sid_ctrl
// Sequencer for the divider: load, one step per quotient bit, then hand-off
// to the output register, plus the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_ctrl
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire sid_status_t status,
    output sid_cmd_t         cmd
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    // output register can take a new beat this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.special)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on capture, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/sid_datapath.sv]
// ----------------------------------------------------------------------------
// sid_datapath
// Magnitude restoring shift-subtract datapath with sign fix-up, special-case
// saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_datapath
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sid_cmd_t                     cmd,
    output sid_status_t                       status,
    input  wire logic signed [DATA_WIDTH-1:0] numerator,
    input  wire logic signed [DATA_WIDTH-1:0] denominator,
    output logic signed [DATA_WIDTH-1:0]      quotient,
    output logic                              overflowed,
    output logic                              zero_divisor
);

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic                  neg_reg, ovf_reg, zdiv_reg;
    logic [DATA_WIDTH-1:0] quotient_reg;
    logic                  overflowed_reg, zero_divisor_reg;

    logic [DATA_WIDTH-1:0] num_u, den_u, num_mag, den_mag;
    logic [DATA_WIDTH-1:0] trial, diff;
    logic [DATA_WIDTH-1:0] result;
    logic                  fits;

    // operand magnitudes; most negative maps onto the sign bit
    assign num_u   = $unsigned(numerator);
    assign den_u   = $unsigned(denominator);
    assign num_mag = num_u[DATA_WIDTH-1] ? (~num_u + 1'b1) : num_u;
    assign den_mag = den_u[DATA_WIDTH-1] ? (~den_u + 1'b1) : den_u;

    // one restoring step: dividend bits shift out of quo_reg into the remainder
    assign trial = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
    assign fits  = (trial >= den_reg);
    assign diff  = trial - den_reg;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.load)
        begin
            rem_next = '0;
            quo_next = num_mag;
        end
        else if (cmd.step)
        begin
            rem_next = fits ? diff : trial;
            quo_next = {quo_reg[DATA_WIDTH-2:0], fits};
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load)
        begin
            den_reg  <= den_mag;
            neg_reg  <= num_u[DATA_WIDTH-1] ^ den_u[DATA_WIDTH-1];
            zdiv_reg <= (den_u == '0);
            ovf_reg  <= (num_u == MOST_NEG) && (den_u == MINUS_ONE);
        end
    end

    // flags are only looked at after a load, so they need no reset
    assign status.special = zdiv_reg || ovf_reg;

    // sign fix-up and saturation
    always_comb
    begin
        if (zdiv_reg || ovf_reg)
        begin
            result = MAX_POS;
        end
        else if (neg_reg)
        begin
            result = ~quo_reg + 1'b1;
        end
        else
        begin
            result = quo_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflowed_reg   <= 1'b0;
            zero_divisor_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            overflowed_reg   <= ovf_reg;
            zero_divisor_reg <= zdiv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            quotient_reg <= result;
        end
    end

    assign quotient     = $signed(quotient_reg);
    assign overflowed   = overflowed_reg;
    assign zero_divisor = zero_divisor_reg;

endmodule

`default_nettype wire

[rtl/signed_int_divider.sv]
// ----------------------------------------------------------------------------
// signed_int_divider
// Signed integer divider, quotient truncated toward zero, no remainder. One
// item is in work at a time: a load, then the shift-subtract loop with one
// step per quotient bit (one quotient bit per cycle through a single compare
// and subtract), then a write of the output register, which waits while a
// result beat held there is stalled. A zero divisor or the most negative
// value over minus one skips the loop; those give the largest positive
// quotient with zero_divisor or overflowed set. A new item is taken as soon
// as the previous one sits in the output register, even while that result
// beat is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module signed_int_divider
    import sid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] numerator,
    input  wire logic signed [DATA_WIDTH-1:0] denominator,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0]      quotient,
    output logic                              overflowed,
    output logic                              zero_divisor
);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    sid_cmd_t    cmd;
    sid_status_t status;

    // sequencer
    sid_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and output register
    sid_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .numerator    (numerator),
        .denominator  (denominator),
        .quotient     (quotient),
        .overflowed   (overflowed),
        .zero_divisor (zero_divisor)
    );

    // checks
    `SID_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted beat did not make the divider busy")
    `SID_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid, !(overflowed && zero_divisor), "overflow and zero divisor flagged together")
    `SID_ASSERT_IMP(a_saturated_value, clk, rst_n, out_valid && (overflowed || zero_divisor), $unsigned(quotient) == MAX_POS, "flagged result not saturated")
    `SID_ASSERT_IMP(a_no_load_while_busy, clk, rst_n, in_stall, !cmd.load, "operands loaded while busy")

endmodule

`default_nettype wire

[verif/quotient_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quotient_checker
// Watches both channels of the signed divider. Every operand beat taken at
// the input is turned into an expected quotient and flags, and every result
// beat is compared field by field with the oldest expectation in the queue.
// ----------------------------------------------------------------------------
module quotient_checker #(
    parameter int DW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [DW-1:0] numerator,
    input  logic signed [DW-1:0] denominator,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [DW-1:0] quotient,
    input  logic                 overflowed,
    input  logic                 zero_divisor,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};
    localparam int REPORT_CAP = 60;

    typedef struct packed {
        logic [DW-1:0] quotient;
        logic          overflowed;
        logic          zero_divisor;
    } div_result_t;

    div_result_t expected_quotients[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // magnitudes, restoring shift-subtract from the top bit down, then sign
    function automatic div_result_t divide_toward_zero(input logic [DW-1:0] num,
                                                       input logic [DW-1:0] den);
        div_result_t   res;
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic [DW-1:0] rem;
        logic [DW-1:0] quo;
        logic          flip;
        res = '0;
        if (den == '0)
        begin
            res.quotient     = MOST_POS;
            res.zero_divisor = 1'b1;
            return res;
        end
        if (num == MOST_NEG && den == ALL_ONES)
        begin
            res.quotient   = MOST_POS;
            res.overflowed = 1'b1;
            return res;
        end
        flip    = num[DW-1] ^ den[DW-1];
        num_mag = num[DW-1] ? ~num + 1'b1 : num;
        den_mag = den[DW-1] ? ~den + 1'b1 : den;
        rem     = '0;
        quo     = '0;
        // partial remainder stays below the sign bit before each shift
        for (int b = DW - 1; b >= 0; b--)
        begin
            rem = {rem[DW-2:0], num_mag[b]};
            if (rem >= den_mag)
            begin
                rem    = rem - den_mag;
                quo[b] = 1'b1;
            end
        end
        res.quotient = flip ? ~quo + 1'b1 : quo;
        return res;
    endfunction

    task automatic flag_mismatch(input string field,
                                 input logic signed [DW-1:0] want,
                                 input logic signed [DW-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endtask

    // result beats first: a result can never belong to this edge's operands
    always @(posedge clk)
    begin : monitor
        div_result_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_quotients.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $error("result beat with nothing expected: quotient %0d", quotient);
                end
                else
                begin
                    want = expected_quotients.pop_front();
                    if (quotient !== $signed(want.quotient))
                        flag_mismatch("quotient", want.quotient, quotient);
                    if (overflowed !== want.overflowed)
                        flag_mismatch("overflowed", want.overflowed, overflowed);
                    if (zero_divisor !== want.zero_divisor)
                        flag_mismatch("zero_divisor", want.zero_divisor, zero_divisor);
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                expected_quotients.push_back(divide_toward_zero(numerator, denominator));
            pending = expected_quotients.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives operand pairs into the signed divider: a directed set of corner
// cases, then random pairs of mixed sizes and signs, with random idling on
// both sides and one long hold-off on the output. The checker does the
// prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int DW         = 32;
    localparam int ITEMS      = 900;
    localparam int HOLD_OFF   = 300;
    localparam int HOLD_AT    = 120;
    localparam int CALM_FROM  = 500;
    localparam int CALM_TO    = 650;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = DW + 8;
    localparam logic signed [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] MOST_POS  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINUS_ONE = {DW{1'b1}};

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic signed [DW-1:0] numerator    = '0;
    logic signed [DW-1:0] denominator  = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic signed [DW-1:0] quotient;
    logic                 overflowed;
    logic                 zero_divisor;

    int fail_count;
    int pending;
    int items_accepted = 0;
    int idle_cycles    = 0;
    int zero_div_items = 0;
    int overflow_items = 0;

    always #5 clk = ~clk;

    signed_int_divider #(
        .DATA_WIDTH (DW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .numerator    (numerator),
        .denominator  (denominator),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .quotient     (quotient),
        .overflowed   (overflowed),
        .zero_divisor (zero_divisor)
    );

    quotient_checker #(
        .DW (DW)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .numerator    (numerator),
        .denominator  (denominator),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .quotient     (quotient),
        .overflowed   (overflowed),
        .zero_divisor (zero_divisor),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // accepted operand beats; read by both sides to pick their phases
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            items_accepted <= items_accepted + 1;
    end

    // watchdog: cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // offer one operand pair, optionally after a gap, and hold it until taken
    task automatic offer_pair(input logic signed [DW-1:0] n,
                              input logic signed [DW-1:0] d);
        int gap;
        gap = 0;
        if (!(items_accepted >= CALM_FROM && items_accepted < CALM_TO)
            && $urandom_range(0, 99) < 34)
            gap = $urandom_range(1, DW + 4);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        numerator   <= n;
        denominator <= d;
        if (d == '0)
            zero_div_items++;
        else if (n == MOST_NEG && d == MINUS_ONE)
            overflow_items++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // random pair drawn from a mix of shapes: full width, small divisors,
    // small operands, awkward divisors, saturation and scaled magnitudes
    task automatic offer_random_pair();
        int                   pick;
        int                   mag;
        logic signed [DW-1:0] n;
        logic signed [DW-1:0] d;
        pick = $urandom_range(0, 99);
        n    = $urandom;
        d    = $urandom;
        if (pick < 40)
        begin
            // both full width as drawn
        end
        else if (pick < 60)
        begin
            mag = $urandom_range(1, 300);
            d   = $urandom_range(0, 1) ? -mag : mag;
        end
        else if (pick < 75)
        begin
            n = int'($urandom_range(0, 2000)) - 1000;
            d = int'($urandom_range(0, 60)) - 30;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0: d = '0;
                1: d = 1;
                2: d = MINUS_ONE;
                3: d = MOST_NEG;
                default: d = MOST_POS;
            endcase
            if ($urandom_range(0, 1))
                n = MOST_NEG;
        end
        else if (pick < 90)
        begin
            n = MOST_NEG;
            d = MINUS_ONE;
        end
        else
        begin
            n = $urandom >> $urandom_range(0, DW - 1);
            d = $urandom >> $urandom_range(0, DW - 1);
            if ($urandom_range(0, 1))
                n = -n;
            if ($urandom_range(0, 1))
                d = -d;
        end
        offer_pair(n, d);
    endtask

    // receiver: random stalls, one long hold-off, then a calm stretch
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !held && items_accepted >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF - 1)
                    @(posedge clk);
                held = 1'b1;
            end
            else if (items_accepted >= CALM_FROM && items_accepted < CALM_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 34);
        end
    end

    // sender and verdict
    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases
        offer_pair(0, 5);
        offer_pair(0, -5);
        offer_pair(0, MOST_NEG);
        offer_pair(MOST_NEG, MINUS_ONE);
        offer_pair(MOST_NEG, 1);
        offer_pair(MOST_POS, 1);
        offer_pair(MOST_POS, MINUS_ONE);
        offer_pair(MOST_NEG, MOST_NEG);
        offer_pair(MOST_POS, MOST_POS);
        offer_pair(MOST_NEG, MOST_POS);
        offer_pair(MOST_POS, MOST_NEG);
        offer_pair(7, 0);
        offer_pair(MOST_NEG, 0);
        offer_pair(0, 0);
        offer_pair(MINUS_ONE, 0);
        offer_pair(-7, 2);
        offer_pair(7, -2);
        offer_pair(-7, -2);
        offer_pair(1, MOST_NEG);
        offer_pair(MINUS_ONE, 1);
        offer_pair(MINUS_ONE, MINUS_ONE);
        offer_pair(MOST_NEG, 2);
        offer_pair(MOST_NEG, -2);
        offer_pair(100, 7);
        offer_pair(-100, 7);

        repeat (ITEMS)
            offer_random_pair();
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray beat
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE)
            @(posedge clk);
        @(negedge clk);

        $display("Divided %0d operand pairs: corner cases, then random widths and signs",
                 items_accepted);
        $display("with %0d zero divisors, %0d saturating pairs and a %0d-cycle output hold-off",
                 zero_div_items, overflow_items, HOLD_OFF);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
